[hdl/kmb_pkg.sv]
// Shared constants for the kinship matrix builder: value format, field widths,
// operation and status codes. No dependencies.
package kmb_pkg;

  localparam int FRACTION_BITS       = 31;
  localparam int VALUE_W             = FRACTION_BITS + 1;
  localparam int NUM_W               = 9;
  localparam int STATUS_W            = 2;
  localparam int DEF_MAX_INDIVIDUALS = 256;

  // Operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_PARENT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd3;

  // Self kinship of an individual with an unknown parent
  localparam logic [VALUE_W-1:0] KIN_HALF = VALUE_W'(1) << (FRACTION_BITS - 1);

endpackage

[hdl/kinship_matrix_builder_top.sv]
// Kinship matrix builder: tabular pedigree kinship in one dual-read memory.
// Depends on kmb_pkg.
//
//  channel   | handshake              | fields
//  ----------+------------------------+----------------------------------------------
//  command   | start / busy           | operation_i, father_number_i, mother_number_i
//  result    | done_o (one-cycle pulse)| kinship_value_o, individual_number_o, status_o
//
// An add of individual n makes one memory pass per earlier individual (two reads,
// one write), then a read of kin(father,mother) and the write of the diagonal.
// A read makes one lookup; a rejected item is answered straight from idle.
// The result is registered and shows in the cycle after the last step; busy drops in that cycle.
// Reset clears the individual count and the control state, not the memory; the memory needs no clearing pass.
// The receiver cannot stall results.
module kinship_matrix_builder_top #(
  parameter int MAX_INDIVIDUALS = kmb_pkg::DEF_MAX_INDIVIDUALS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation_i,
  input  logic [kmb_pkg::NUM_W-1:0]    father_number_i,
  input  logic [kmb_pkg::NUM_W-1:0]    mother_number_i,
  output logic                         done_o,
  output logic [kmb_pkg::VALUE_W-1:0]  kinship_value_o,
  output logic [kmb_pkg::NUM_W-1:0]    individual_number_o,
  output logic [kmb_pkg::STATUS_W-1:0] status_o
);

  localparam int IDXW  = $clog2(MAX_INDIVIDUALS);
  localparam int CW    = $clog2(MAX_INDIVIDUALS + 1);
  localparam int NW    = (CW > kmb_pkg::NUM_W) ? CW : kmb_pkg::NUM_W;
  localparam int AW    = 2 * IDXW;
  localparam int DEPTH = 1 << AW;
  localparam int VW    = kmb_pkg::VALUE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WALK,
    ST_SELF,
    ST_FINISH
  } state_e;

  // Only the lower triangle is kept: kin(p,q) lives at row max(p,q), column min(p,q).
  function automatic logic [AW-1:0] cell_addr(logic [NW-1:0] p, logic [NW-1:0] q);
    logic [NW-1:0] hi;
    logic [NW-1:0] lo;
    hi = (p > q) ? p : q;
    lo = (p > q) ? q : p;
    hi = hi - NW'(1);
    lo = lo - NW'(1);
    return {hi[IDXW-1:0], lo[IDXW-1:0]};
  endfunction

  state_e          state_q;
  logic [NW-1:0]   count_q;
  logic [NW-1:0]   n_q;
  logic [NW-1:0]   j_q;
  logic [NW-1:0]   wj_q;
  logic [NW-1:0]   fa_q;
  logic [NW-1:0]   mo_q;
  logic            pend_q;
  logic            z0_q;
  logic            z1_q;
  logic            done_q;
  logic [VW-1:0]   value_q;
  logic [kmb_pkg::NUM_W-1:0]    num_q;
  logic [kmb_pkg::STATUS_W-1:0] status_q;

  logic [VW-1:0]   kin_mem [DEPTH];
  logic [VW-1:0]   rd0_q;
  logic [VW-1:0]   rd1_q;
  logic [AW-1:0]   mem_raddr0;
  logic [AW-1:0]   mem_raddr1;
  logic [AW-1:0]   mem_waddr;
  logic [VW-1:0]   mem_wdata;
  logic            mem_we;

  logic [NW-1:0]   fa_in;
  logic [NW-1:0]   mo_in;
  logic [VW-1:0]   k0;
  logic [VW-1:0]   k1;
  logic [VW:0]     pair_sum;
  logic [VW-1:0]   self_kin;
  logic            accept;

  assign fa_in  = NW'(father_number_i);
  assign mo_in  = NW'(mother_number_i);
  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // An unknown parent contributes zero.
  assign k0       = z0_q ? '0 : rd0_q;
  assign k1       = z1_q ? '0 : rd1_q;
  assign pair_sum = {1'b0, k0} + {1'b0, k1};
  assign self_kin = kmb_pkg::KIN_HALF + (k0 >> 1);

  // Walk reads touch rows below n only, while writes go to row n: no overlap.
  always_comb begin
    mem_raddr0 = cell_addr(fa_q, j_q);
    mem_raddr1 = cell_addr(mo_q, j_q);
    unique case (state_q)
      ST_IDLE: mem_raddr0 = cell_addr(fa_in, mo_in);
      ST_SELF: mem_raddr0 = cell_addr(fa_q, mo_q);
      default: ;
    endcase
    mem_we    = pend_q || (state_q == ST_FINISH);
    mem_waddr = pend_q ? cell_addr(n_q, wj_q) : cell_addr(n_q, n_q);
    mem_wdata = pend_q ? pair_sum[VW:1] : self_kin;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      kin_mem[mem_waddr] <= mem_wdata;
    end
    rd0_q <= kin_mem[mem_raddr0];
    rd1_q <= kin_mem[mem_raddr1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      n_q      <= '0;
      j_q      <= '0;
      wj_q     <= '0;
      fa_q     <= '0;
      mo_q     <= '0;
      pend_q   <= 1'b0;
      z0_q     <= 1'b0;
      z1_q     <= 1'b0;
      done_q   <= 1'b0;
      value_q  <= '0;
      num_q    <= '0;
      status_q <= kmb_pkg::STATUS_OK;
    end else begin
      done_q <= 1'b0;
      pend_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            value_q  <= '0;
            num_q    <= '0;
            status_q <= kmb_pkg::STATUS_OK;
            if (operation_i == kmb_pkg::OP_READ) begin
              if (fa_in == '0 || mo_in == '0 || fa_in > count_q || mo_in > count_q) begin
                done_q   <= 1'b1;
                status_q <= kmb_pkg::STATUS_RANGE;
              end else begin
                state_q <= ST_READ;
              end
            end else if (count_q == NW'(MAX_INDIVIDUALS)) begin
              done_q   <= 1'b1;
              status_q <= kmb_pkg::STATUS_FULL;
            end else if (fa_in > count_q || mo_in > count_q) begin
              done_q   <= 1'b1;
              status_q <= kmb_pkg::STATUS_PARENT;
            end else begin
              fa_q    <= fa_in;
              mo_q    <= mo_in;
              n_q     <= count_q + NW'(1);
              j_q     <= NW'(1);
              state_q <= (count_q == '0) ? ST_SELF : ST_WALK;
            end
          end
        end
        ST_READ: begin
          done_q  <= 1'b1;
          value_q <= rd0_q;
          state_q <= ST_IDLE;
        end
        ST_WALK: begin
          // Issue reads for row j; the write for it follows next cycle.
          pend_q <= 1'b1;
          wj_q   <= j_q;
          z0_q   <= (fa_q == '0);
          z1_q   <= (mo_q == '0);
          j_q    <= j_q + NW'(1);
          if (j_q == n_q - NW'(1)) begin
            state_q <= ST_SELF;
          end
        end
        ST_SELF: begin
          z0_q    <= (fa_q == '0) || (mo_q == '0);
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          done_q   <= 1'b1;
          value_q  <= self_kin;
          num_q    <= n_q[kmb_pkg::NUM_W-1:0];
          status_q <= kmb_pkg::STATUS_OK;
          count_q  <= n_q;
          state_q  <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o              = done_q;
  assign kinship_value_o     = value_q;
  assign individual_number_o = num_q;
  assign status_o            = status_q;

endmodule

[verif/tb_kinship_matrix_builder_top.sv]
`timescale 1ns / 1ps
// Testbench for kinship_matrix_builder_top: adds individuals and reads kinship entries,
// predicts each result from its own kinship table or takes it from a fixed row, and compares it field by field.
// Depends on kmb_pkg and the block's RTL.
module tb_kinship_matrix_builder_top;

  localparam int MAX_IND      = kmb_pkg::DEF_MAX_INDIVIDUALS;
  localparam int RANDOM_ITEMS = 1230;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int SETTLE_CYCLES = MAX_IND + 40;

  typedef logic [kmb_pkg::VALUE_W-1:0]  kin_t;
  typedef logic [kmb_pkg::NUM_W-1:0]    num_t;
  typedef logic [kmb_pkg::STATUS_W-1:0] status_t;

  typedef struct packed {
    kin_t    value;
    num_t    number;
    status_t status;
  } kin_result_t;

  typedef struct packed {
    logic        op;
    num_t        father;
    num_t        mother;
    logic        typed;
    kin_result_t res;
  } pedigree_row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  logic    operation_i = kmb_pkg::OP_ADD;
  num_t    father_number_i = '0;
  num_t    mother_number_i = '0;
  logic    done_o;
  kin_t    kinship_value_o;
  num_t    individual_number_o;
  status_t status_o;

  kin_t          kin_table [1:MAX_IND][1:MAX_IND];
  int unsigned   people_count = 0;
  kin_result_t   kinship_results_q[$];
  pedigree_row_t pedigree_rows[$];
  int            error_count = 0;
  int            cycle_count = 0;

  kinship_matrix_builder_top u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .operation_i         (operation_i),
    .father_number_i     (father_number_i),
    .mother_number_i     (mother_number_i),
    .done_o              (done_o),
    .kinship_value_o     (kinship_value_o),
    .individual_number_o (individual_number_o),
    .status_o            (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(string what, longint unsigned exp_v, longint unsigned got_v);
    $display("mismatch %s: expected 0x%0h, got 0x%0h (cycle %0d)",
             what, exp_v, got_v, cycle_count);
    error_count++;
  endtask

  function automatic kin_t kin_of_pair(int unsigned p, int unsigned q);
    if (p == 0 || q == 0) return '0;
    return kin_table[p][q];
  endfunction

  // Apply one item to the local pedigree and return the result it must give.
  function automatic kin_result_t apply_pedigree_item(logic op, num_t f, num_t m);
    kin_result_t   r;
    int unsigned   n;
    int unsigned   j;
    logic [kmb_pkg::VALUE_W:0] sum;
    r.value  = '0;
    r.number = '0;
    r.status = kmb_pkg::STATUS_OK;
    if (op == kmb_pkg::OP_READ) begin
      if (f == 0 || m == 0 || f > people_count || m > people_count) begin
        r.status = kmb_pkg::STATUS_RANGE;
      end else begin
        r.value = kin_table[f][m];
      end
    end else if (people_count >= MAX_IND) begin
      r.status = kmb_pkg::STATUS_FULL;
    end else if (f > people_count || m > people_count) begin
      r.status = kmb_pkg::STATUS_PARENT;
    end else begin
      n = people_count + 1;
      for (j = 1; j < n; j++) begin
        sum = {1'b0, kin_of_pair(f, j)} + {1'b0, kin_of_pair(m, j)};
        kin_table[n][j] = sum[kmb_pkg::VALUE_W:1];
        kin_table[j][n] = sum[kmb_pkg::VALUE_W:1];
      end
      r.value = kmb_pkg::KIN_HALF + (kin_of_pair(f, m) >> 1);
      kin_table[n][n] = r.value;
      people_count = n;
      r.number = num_t'(n);
    end
    return r;
  endfunction

  task automatic add_row(logic op, int f, int m, logic typed,
                         kin_t value, int number, status_t status);
    pedigree_row_t row;
    row.op         = op;
    row.father     = num_t'(f);
    row.mother     = num_t'(m);
    row.typed      = typed;
    row.res.value  = value;
    row.res.number = num_t'(number);
    row.res.status = status;
    pedigree_rows.push_back(row);
  endtask

  task automatic send_item(logic op, num_t f, num_t m, logic typed, kin_result_t typed_res);
    kin_result_t predicted;
    start           <= 1'b1;
    operation_i     <= op;
    father_number_i <= f;
    mother_number_i <= m;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = apply_pedigree_item(op, f, m);
    kinship_results_q.push_back(typed ? typed_res : predicted);
  endtask

  task automatic idle_sender(int cycles);
    if (cycles == 0) return;
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold off until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (kinship_results_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Favor recent individuals so that inbreeding builds up over generations.
  function automatic num_t pick_parent(int unsigned n);
    int unsigned r;
    if (n == 0) return '0;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r < 5) return num_t'($urandom_range((n > 4) ? n - 4 : 1, n));
    return num_t'($urandom_range(1, n));
  endfunction

  task automatic random_item(output logic op, output num_t f, output num_t m);
    int unsigned pick;
    int unsigned n;
    n    = people_count;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      op = kmb_pkg::OP_ADD;
      f  = pick_parent(n);
      m  = pick_parent(n);
      if ($urandom_range(0, 9) == 0) m = f;
    end else if (pick < 80) begin
      op = kmb_pkg::OP_READ;
      f  = (n == 0) ? '0 : num_t'($urandom_range(1, n));
      m  = (n == 0) ? '0 : num_t'($urandom_range(1, n));
    end else if (pick < 90) begin
      // add naming a parent that does not exist yet
      op = kmb_pkg::OP_ADD;
      f  = num_t'($urandom_range(0, MAX_IND));
      m  = num_t'($urandom_range(0, MAX_IND));
      if (n < MAX_IND) begin
        if ($urandom_range(0, 1) == 1) f = num_t'($urandom_range(n + 1, MAX_IND));
        else m = num_t'($urandom_range(n + 1, MAX_IND));
      end
    end else begin
      op = kmb_pkg::OP_READ;
      f  = num_t'($urandom_range(0, MAX_IND));
      m  = num_t'($urandom_range(0, MAX_IND));
      case ($urandom_range(0, 3))
        0: f = '0;
        1: m = '0;
        2: if (n < MAX_IND) f = num_t'($urandom_range(n + 1, MAX_IND));
        default: if (n < MAX_IND) m = num_t'($urandom_range(n + 1, MAX_IND));
      endcase
    end
  endtask

  always @(posedge clk_i) begin : result_check
    kin_result_t want;
    if (rst_ni && done_o) begin
      if (kinship_results_q.size() == 0) begin
        report_mismatch("result with none pending", 0, kinship_value_o);
      end else begin
        want = kinship_results_q.pop_front();
        if (kinship_value_o !== want.value)
          report_mismatch("kinship_value", want.value, kinship_value_o);
        if (individual_number_o !== want.number)
          report_mismatch("individual_number", want.number, individual_number_o);
        if (status_o !== want.status)
          report_mismatch("status", want.status, status_o);
      end
    end
  end

  initial begin : stimulus
    pedigree_row_t row;
    kin_result_t   no_result;
    logic          op;
    num_t          f;
    num_t          m;
    logic          calm;
    no_result = '0;
    calm      = 1'b0;

    // empty table: every read and every add with a parent is rejected
    add_row(kmb_pkg::OP_READ, 1, 1, 1'b1, '0, 0, kmb_pkg::STATUS_RANGE);
    add_row(kmb_pkg::OP_READ, 0, 0, 1'b1, '0, 0, kmb_pkg::STATUS_RANGE);
    add_row(kmb_pkg::OP_READ, MAX_IND, MAX_IND, 1'b1, '0, 0, kmb_pkg::STATUS_RANGE);
    add_row(kmb_pkg::OP_ADD, 1, 0, 1'b1, '0, 0, kmb_pkg::STATUS_PARENT);
    add_row(kmb_pkg::OP_ADD, 0, MAX_IND, 1'b1, '0, 0, kmb_pkg::STATUS_PARENT);
    add_row(kmb_pkg::OP_ADD, MAX_IND, MAX_IND, 1'b1, '0, 0, kmb_pkg::STATUS_PARENT);
    // founders and single-parent individuals sit at one half
    add_row(kmb_pkg::OP_ADD, 0, 0, 1'b1, kmb_pkg::KIN_HALF, 1, kmb_pkg::STATUS_OK);
    add_row(kmb_pkg::OP_ADD, 0, 1, 1'b1, kmb_pkg::KIN_HALF, 2, kmb_pkg::STATUS_OK);
    add_row(kmb_pkg::OP_ADD, 1, 0, 1'b1, kmb_pkg::KIN_HALF, 3, kmb_pkg::STATUS_OK);
    add_row(kmb_pkg::OP_ADD, 2, 3, 1'b0, '0, 0, kmb_pkg::STATUS_OK);
    // identical parents use the stored self kinship
    add_row(kmb_pkg::OP_ADD, 4, 4, 1'b0, '0, 0, kmb_pkg::STATUS_OK);
    add_row(kmb_pkg::OP_ADD, 5, 5, 1'b0, '0, 0, kmb_pkg::STATUS_OK);
    add_row(kmb_pkg::OP_ADD, 6, 4, 1'b0, '0, 0, kmb_pkg::STATUS_OK);
    add_row(kmb_pkg::OP_READ, 1, 1, 1'b1, kmb_pkg::KIN_HALF, 0, kmb_pkg::STATUS_OK);
    add_row(kmb_pkg::OP_READ, 7, 7, 1'b0, '0, 0, kmb_pkg::STATUS_OK);
    add_row(kmb_pkg::OP_READ, 1, 7, 1'b0, '0, 0, kmb_pkg::STATUS_OK);
    add_row(kmb_pkg::OP_READ, 7, 3, 1'b0, '0, 0, kmb_pkg::STATUS_OK);
    add_row(kmb_pkg::OP_READ, 0, 3, 1'b1, '0, 0, kmb_pkg::STATUS_RANGE);
    add_row(kmb_pkg::OP_READ, 3, 0, 1'b1, '0, 0, kmb_pkg::STATUS_RANGE);
    add_row(kmb_pkg::OP_READ, 8, 1, 1'b1, '0, 0, kmb_pkg::STATUS_RANGE);
    add_row(kmb_pkg::OP_READ, 1, 8, 1'b1, '0, 0, kmb_pkg::STATUS_RANGE);
    add_row(kmb_pkg::OP_ADD, 8, 0, 1'b1, '0, 0, kmb_pkg::STATUS_PARENT);
    add_row(kmb_pkg::OP_ADD, 7, 8, 1'b1, '0, 0, kmb_pkg::STATUS_PARENT);
    add_row(kmb_pkg::OP_ADD, 0, 0, 1'b1, kmb_pkg::KIN_HALF, 8, kmb_pkg::STATUS_OK);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (pedigree_rows[i]) begin
      row = pedigree_rows[i];
      idle_sender(pick_gap());
      send_item(row.op, row.father, row.mother, row.typed, row.res);
    end
    drain_results();

    // random part fills the table, then keeps hitting it once it is full
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 100 == 0) calm = ($urandom_range(0, 2) == 0);
      if (k % 300 == 299) drain_results();
      else idle_sender(calm ? 0 : pick_gap());
      random_item(op, f, m);
      send_item(op, f, m, 1'b0, no_result);
    end

    start <= 1'b0;
    while (kinship_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

[files.f]
hdl/kmb_pkg.sv
hdl/kinship_matrix_builder_top.sv
verif/tb_kinship_matrix_builder_top.sv
